// ===== src/r2fft_pkg.sv =====
package r2fft_pkg;

  // Frame geometry and field widths.
  localparam int MAX_POINTS     = 1024;
  localparam int LOG2_MAX       = $clog2(MAX_POINTS);
  localparam int SAMPLE_WIDTH   = 16;
  localparam int RESULT_WIDTH   = 28;
  localparam int TWIDDLE_WIDTH  = 16;
  localparam int BIN_WIDTH      = 10;
  localparam int ROM_SIZE       = (MAX_POINTS / 2 > 0) ? MAX_POINTS / 2 : 1;
  localparam int ROM_IDX_WIDTH  = (LOG2_MAX > 1) ? LOG2_MAX - 1 : 1;
  localparam int TW_FRAC        = TWIDDLE_WIDTH - 1;
  localparam longint PI_Q28     = 64'sd843314857;

  // Configuration port.
  localparam int CFG_IDX_WIDTH  = 1;
  localparam int CFG_DATA_WIDTH = 4;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_INVERSE = 1'b0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SIZE    = 1'b1;

  // Commands.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef struct packed {
    logic                           cmd;
    logic signed [SAMPLE_WIDTH-1:0] sample_real;
    logic signed [SAMPLE_WIDTH-1:0] sample_imag;
  } fft_in_t;

  typedef struct packed {
    logic signed [RESULT_WIDTH-1:0] result_real;
    logic signed [RESULT_WIDTH-1:0] result_imag;
    logic [BIN_WIDTH-1:0]           bin_index;
    logic                           last_flag;
  } fft_out_t;

  // Quotient of two non-negative values by shift and subtract.
  function automatic longint udiv(longint num, longint den);
    longint q;
    longint rem;
    q   = 0;
    rem = 0;
    for (int i = 62; i >= 0; i--) begin
      rem = (rem <<< 1) | ((num >>> i) & longint'(1));
      if (rem >= den) begin
        rem = rem - den;
        q   = q | (longint'(1) <<< i);
      end
    end
    return q;
  endfunction

  // Alternating Taylor series in Q28, evaluated at elaboration only.
  function automatic longint series(longint x, longint t0, int n0);
    longint x2;
    longint sum;
    longint t;
    int     n;
    bit     add;
    x2  = (x * x) >>> 28;
    sum = 0;
    t   = t0;
    n   = n0;
    add = 1'b1;
    while (t != 0 && n < 60) begin
      sum = add ? sum + t : sum - t;
      add = !add;
      t   = udiv((t * x2) >>> 28, longint'((n + 1) * (n + 2)));
      n   = n + 2;
    end
    return sum;
  endfunction

  // Round a Q28 value half up into Q1.TW_FRAC and saturate.
  function automatic logic signed [TWIDDLE_WIDTH-1:0] to_twiddle(longint v);
    longint r;
    longint hi;
    hi = (longint'(1) <<< TW_FRAC) - 1;
    r  = (v + (longint'(1) <<< (27 - TW_FRAC))) >>> (28 - TW_FRAC);
    if (r > hi) r = hi;
    if (r < -hi - 1) r = -hi - 1;
    return TWIDDLE_WIDTH'(r);
  endfunction

  function automatic logic signed [TWIDDLE_WIDTH-1:0] tw_cos(int r);
    longint x;
    x = (2 * PI_Q28 * longint'(r)) >>> LOG2_MAX;
    return to_twiddle(series(x, longint'(1) <<< 28, 0));
  endfunction

  function automatic logic signed [TWIDDLE_WIDTH-1:0] tw_sin(int r);
    longint x;
    x = (2 * PI_Q28 * longint'(r)) >>> LOG2_MAX;
    return to_twiddle(series(x, x, 1));
  endfunction

endpackage

// ===== src/radix2_fft_ifft.sv =====
// Channel   Direction  Payload    Handshake
// in        input      fft_in_t   in_valid_i / in_stall_o
// out       output     fft_out_t  out_valid_o / out_stall_i
// cfg       input      4 bits     cfg_we_i / cfg_index_i
//
// The push that completes a frame starts the butterflies; each runs in turn through the states
// RD_B, RD_A, M0 to M4, WR_A and WR_B, on the shared multiplier and the one-read/one-write
// sample store. A pop stalls the input while it reads the store and then loads the output
// register, plus any wait for the output register.
// Reset sets all control state (inverse off, log2 size 10); the sample store is not cleared.
// in_stall_o is also high during a configuration write; a held result does not block pushes.
module radix2_fft_ifft
  import r2fft_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  fft_in_t                   in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output fft_out_t                  out_data_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index_i,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata_i
);

  localparam int AW   = LOG2_MAX;
  localparam int LW   = $clog2(LOG2_MAX + 1);
  localparam int RW   = RESULT_WIDTH;
  localparam int TW   = TWIDDLE_WIDTH;
  localparam int PW   = TW + RW;
  localparam int SW   = PW + 2;
  localparam logic signed [SW-1:0] SAT_HI = SW'((longint'(1) <<< (RW - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);
  localparam logic signed [SW-1:0] RND    = SW'(longint'(1) <<< (TW_FRAC - 1));

  typedef enum logic [3:0] {
    S_IDLE, S_POP_RD, S_POP_OUT, S_RD_B, S_RD_A,
    S_M0, S_M1, S_M2, S_M3, S_M4, S_WR_A, S_WR_B
  } state_e;

  function automatic logic signed [RW-1:0] sat(logic signed [SW-1:0] x);
    if (x > SAT_HI) return SAT_HI[RW-1:0];
    if (x < SAT_LO) return SAT_LO[RW-1:0];
    return x[RW-1:0];
  endfunction

  // Constant twiddle tables.
  logic signed [TW-1:0] rom_cos [ROM_SIZE];
  logic signed [TW-1:0] rom_sin [ROM_SIZE];
  for (genvar r = 0; r < ROM_SIZE; r++) begin : g_rom
    localparam logic signed [TW-1:0] COS_V = tw_cos(r);
    localparam logic signed [TW-1:0] SIN_V = tw_sin(r);
    assign rom_cos[r] = COS_V;
    assign rom_sin[r] = SIN_V;
  end

  state_e            state_q;
  logic              inverse_q;
  logic [3:0]        size_log2_q;
  logic [AW:0]       load_count_q;
  logic [AW:0]       read_count_q;
  logic              ready_q;
  logic [LW-1:0]     stage_q;
  logic [AW-1:0]     bf_q;
  logic signed [TW-1:0] wr_q, wi_q;
  logic signed [RW-1:0] br_q, bi_q, ur_q, ui_q;
  logic signed [PW-1:0] prod_q;
  logic signed [SW-1:0] accr_q, acci_q;
  logic              out_valid_q;
  fft_out_t          out_q;
  logic [2*RW-1:0]   rdata_q;

  // Effective transform size.
  logic [LW-1:0]     eff_l;
  logic [AW:0]       n_pts;
  always_comb begin
    if (size_log2_q == 4'd0) eff_l = LW'(1);
    else if (int'(size_log2_q) > LOG2_MAX) eff_l = LW'(LOG2_MAX);
    else eff_l = LW'(size_log2_q);
  end
  assign n_pts = (AW + 1)'(1) << eff_l;

  // Butterfly addressing: insert a zero bit at position stage-1.
  logic [AW-1:0] half_mask, addr_a, addr_b, bf_last, tw_full;
  logic [ROM_IDX_WIDTH-1:0] tw_idx;
  always_comb begin
    half_mask = (AW'(1) << (stage_q - LW'(1))) - AW'(1);
    addr_a    = ((bf_q & ~half_mask) << 1) | (bf_q & half_mask);
    addr_b    = addr_a | (half_mask + AW'(1));
    bf_last   = n_pts[AW:1] - AW'(1);
    tw_full   = (bf_q & half_mask) << (LW'(LOG2_MAX) - stage_q);
    tw_idx    = tw_full[ROM_IDX_WIDTH-1:0];
  end

  // Bit-reversed load position.
  logic [AW-1:0] load_idx, load_rev, load_pos;
  logic [AW:0]   load_eff;
  always_comb begin
    load_eff = (ready_q || load_count_q >= n_pts) ? '0 : load_count_q;
    load_idx = load_eff[AW-1:0];
    for (int i = 0; i < AW; i++) load_rev[i] = load_idx[AW-1-i];
    load_pos = load_rev >> (LW'(LOG2_MAX) - eff_l);
  end

  // Shared multiplier operand selection.
  logic signed [TW-1:0] mul_a;
  logic signed [RW-1:0] mul_b;
  always_comb begin
    case (state_q)
      S_M0:    begin mul_a = wr_q; mul_b = br_q; end
      S_M1:    begin mul_a = wi_q; mul_b = bi_q; end
      S_M2:    begin mul_a = wr_q; mul_b = bi_q; end
      S_M3:    begin mul_a = wi_q; mul_b = br_q; end
      default: begin mul_a = wr_q; mul_b = br_q; end
    endcase
  end

  // Rounded twiddle products and butterfly outputs.
  logic signed [SW-1:0] tr, ti;
  logic signed [RW-1:0] sum_r, sum_i, dif_r, dif_i;
  assign tr    = (accr_q + RND) >>> TW_FRAC;
  assign ti    = (acci_q + RND) >>> TW_FRAC;
  assign sum_r = sat(SW'(ur_q) + tr);
  assign sum_i = sat(SW'(ui_q) + ti);
  assign dif_r = sat(SW'(ur_q) - tr);
  assign dif_i = sat(SW'(ui_q) - ti);

  // Store port control.
  logic            in_fire, out_free;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic            wr_en;
  logic [2*RW-1:0] wr_data;
  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    rd_addr = read_count_q[AW-1:0];
    wr_addr = load_pos;
    wr_en   = 1'b0;
    wr_data = {sat(SW'(in_data_i.sample_real)), sat(SW'(in_data_i.sample_imag))};
    case (state_q)
      S_IDLE:  wr_en = in_fire && !cfg_we_i && in_data_i.cmd == CMD_PUSH;
      S_RD_B:  rd_addr = addr_b;
      S_RD_A:  rd_addr = addr_a;
      S_WR_A:  begin wr_en = 1'b1; wr_addr = addr_a; wr_data = {sum_r, sum_i}; end
      S_WR_B:  begin wr_en = 1'b1; wr_addr = addr_b; wr_data = {dif_r, dif_i}; end
      default: ;
    endcase
  end

  // Sample store.
  logic [2*RW-1:0] store_mem [MAX_POINTS];
  always_ff @(posedge clk_i) begin
    if (wr_en) store_mem[wr_addr] <= wr_data;
    rdata_q <= store_mem[rd_addr];
  end

  assign in_stall_o  = state_q != S_IDLE || cfg_we_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Result formatting for a pop.
  logic signed [RW-1:0] pop_re, pop_im;
  always_comb begin
    pop_re = rdata_q[2*RW-1:RW];
    pop_im = rdata_q[RW-1:0];
    if (inverse_q) begin
      pop_re = pop_re >>> eff_l;
      pop_im = pop_im >>> eff_l;
    end
  end

  // Sequencer, counters and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      inverse_q    <= 1'b0;
      size_log2_q  <= 4'd10;
      load_count_q <= '0;
      read_count_q <= '0;
      ready_q      <= 1'b0;
      stage_q      <= LW'(1);
      bf_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      // A result leaving the output register; a pop in its last cycle refills it.
      if (out_valid_q && !out_stall_i && state_q != S_POP_OUT) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cfg_we_i) begin
            if (cfg_index_i == CFG_INVERSE) inverse_q <= cfg_wdata_i[0];
            if (cfg_index_i == CFG_SIZE) size_log2_q <= cfg_wdata_i;
            load_count_q <= '0;
            read_count_q <= '0;
            ready_q      <= 1'b0;
          end else if (in_fire) begin
            if (in_data_i.cmd == CMD_PUSH) begin
              ready_q      <= 1'b0;
              read_count_q <= '0;
              if (load_eff + (AW + 1)'(1) == n_pts) begin
                load_count_q <= '0;
                stage_q      <= LW'(1);
                bf_q         <= '0;
                state_q      <= S_RD_B;
              end else begin
                load_count_q <= load_eff + (AW + 1)'(1);
              end
            end else if (ready_q && read_count_q < n_pts) begin
              state_q <= S_POP_RD;
            end
          end
        end
        S_POP_RD: state_q <= S_POP_OUT;
        S_POP_OUT: begin
          if (out_free) begin
            out_valid_q           <= 1'b1;
            out_q.result_real     <= pop_re;
            out_q.result_imag     <= pop_im;
            out_q.bin_index       <= read_count_q[BIN_WIDTH-1:0];
            out_q.last_flag       <= read_count_q == n_pts - (AW + 1)'(1);
            if (read_count_q + (AW + 1)'(1) >= n_pts) begin
              read_count_q <= '0;
              ready_q      <= 1'b0;
            end else begin
              read_count_q <= read_count_q + (AW + 1)'(1);
            end
            state_q <= S_IDLE;
          end
        end
        S_RD_B: begin
          wr_q    <= rom_cos[tw_idx];
          wi_q    <= inverse_q ? rom_sin[tw_idx] : -rom_sin[tw_idx];
          state_q <= S_RD_A;
        end
        S_RD_A: begin
          br_q    <= rdata_q[2*RW-1:RW];
          bi_q    <= rdata_q[RW-1:0];
          state_q <= S_M0;
        end
        S_M0: begin
          ur_q    <= rdata_q[2*RW-1:RW];
          ui_q    <= rdata_q[RW-1:0];
          prod_q  <= mul_a * mul_b;
          state_q <= S_M1;
        end
        S_M1: begin
          accr_q  <= SW'(prod_q);
          prod_q  <= mul_a * mul_b;
          state_q <= S_M2;
        end
        S_M2: begin
          accr_q  <= accr_q - SW'(prod_q);
          prod_q  <= mul_a * mul_b;
          state_q <= S_M3;
        end
        S_M3: begin
          acci_q  <= SW'(prod_q);
          prod_q  <= mul_a * mul_b;
          state_q <= S_M4;
        end
        S_M4: begin
          acci_q  <= acci_q + SW'(prod_q);
          state_q <= S_WR_A;
        end
        S_WR_A: state_q <= S_WR_B;
        S_WR_B: begin
          if (bf_q == bf_last) begin
            bf_q <= '0;
            if (stage_q == eff_l) begin
              ready_q      <= 1'b1;
              read_count_q <= '0;
              state_q      <= S_IDLE;
            end else begin
              stage_q <= stage_q + LW'(1);
              state_q <= S_RD_B;
            end
          end else begin
            bf_q    <= bf_q + AW'(1);
            state_q <= S_RD_B;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
